FILE: design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned EFF_W       = ADDR_W + 1;

  // probe limit
  localparam int unsigned PROBE_CAP = 16;

  // field widths
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CFG_SIZE_W  = 11;
  localparam int unsigned CFG_PROBE_W = 5;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_IDX_W   = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROBES = 1'b1;

  // register reset values
  localparam logic [CFG_SIZE_W-1:0]  TABLE_SIZE_RST = CFG_SIZE_W'(1024);
  localparam logic [CFG_PROBE_W-1:0] MAX_PROBES_RST = CFG_PROBE_W'(10);

  // result codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;
  localparam logic signed [VAL_W-1:0] MISS_KEY   = -32'sd1;
  localparam logic signed [VAL_W-1:0] MISS_VALUE = 32'sd0;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_REMOVE = 2'd2
  } req_type_e;

  typedef logic [KEY_W-1:0]        key_t;
  typedef logic signed [VAL_W-1:0] value_t;

  // one table slot as stored in memory
  typedef struct packed {
    logic   used;
    key_t   key;
    value_t data;
  } slot_t;

endpackage

FILE: design/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_req_if / lpht_rsp_if
// Valid/ready channels carrying requests and results of the hash table.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  logic                 valid;
  logic                 ready;
  lpht_pkg::req_type_e  req_type;
  lpht_pkg::key_t       key;
  lpht_pkg::value_t     value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lpht_rsp_if;
  logic             valid;
  logic             ready;
  logic             status;
  lpht_pkg::value_t found_key;
  lpht_pkg::value_t found_value;

  modport source (output valid, output status, output found_key, output found_value,
                  input ready);
  modport sink   (input valid, input status, input found_key, input found_value,
                  output ready);
endinterface

FILE: design/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, else read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

FILE: design/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing key/value table with linear probing over one slot memory.
// ----------------------------------------------------------------------------
// Flow: one request at a time, taken only while idle. The home slot comes from
//   a two-bit-per-cycle remainder unit, then one memory read per slot examined
//   (1..16 slots, or none at all).
// Reset: a clearing pass over the TABLE_DEPTH slots empties each one; requests
//   are held off meanwhile, configuration writes are taken as ever.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lpht_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lpht_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  lpht_req_if.sink                         req_i,
  lpht_rsp_if.source                       rsp_o
);

  import lpht_pkg::*;

  localparam int unsigned DIV_STEPS = (KEY_W + 2) / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned SH_W      = 2 * DIV_STEPS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_HOME  = 3'd3;
  localparam logic [2:0] ST_PROBE = 3'd4;

  // one restoring remainder step
  function automatic logic [ADDR_W-1:0] mod_step(input logic [ADDR_W-1:0] rem,
                                                 input logic              dbit,
                                                 input logic [EFF_W-1:0]  size);
    logic [EFF_W-1:0] t;
    t = {rem, dbit};
    if (t >= size) begin
      t = t - size;
    end
    return ADDR_W'(t);
  endfunction

  logic [2:0]             state_q, state_d;
  logic [CFG_SIZE_W-1:0]  size_cfg_q;
  logic [CFG_PROBE_W-1:0] probe_cfg_q;
  logic [ADDR_W-1:0]      clr_q, clr_d;
  req_type_e              req_q, req_d;
  key_t                   key_q, key_d;
  value_t                 val_q, val_d;
  logic [SH_W-1:0]        sh_q, sh_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]      rem_q, rem_d;
  logic [ADDR_W-1:0]      cur_q, cur_d;
  logic [ADDR_W-1:0]      nxt_q, nxt_d;
  logic [CFG_PROBE_W-1:0] n_q, n_d;
  logic                   rsp_valid_q, rsp_valid_d;
  logic                   rsp_status_q;
  value_t                 rsp_key_q, rsp_value_q;

  logic [EFF_W-1:0]       eff_size;
  logic [CFG_PROBE_W-1:0] eff_probes;
  logic                   out_free;
  logic                   req_ok;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_addr;
  slot_t                  ram_wdata, ram_rdata;
  logic                   res_set, res_status;
  value_t                 res_key, res_value;
  logic                   hit;

  // wrap to slot zero at the end of the table in use
  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] h,
                                                  input logic [EFF_W-1:0]  size);
    logic [EFF_W-1:0] inc;
    inc = {1'b0, h} + EFF_W'(1);
    return (inc == size) ? '0 : ADDR_W'(inc);
  endfunction

  // effective size and probe limit
  always_comb begin
    if (size_cfg_q == '0) begin
      eff_size = EFF_W'(1);
    end else if (32'(size_cfg_q) > 32'(TABLE_DEPTH)) begin
      eff_size = EFF_W'(TABLE_DEPTH);
    end else begin
      eff_size = EFF_W'(size_cfg_q);
    end
    eff_probes = (32'(probe_cfg_q) > 32'(PROBE_CAP)) ? CFG_PROBE_W'(PROBE_CAP) : probe_cfg_q;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg_q  <= TABLE_SIZE_RST;
      probe_cfg_q <= MAX_PROBES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TABLE_SIZE: size_cfg_q  <= CFG_SIZE_W'(cfg_wdata_i);
        CFG_MAX_PROBES: probe_cfg_q <= CFG_PROBE_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_ok      = (req_q == REQ_INSERT) || (req_q == REQ_SEARCH) ||
                       (req_q == REQ_REMOVE);
  assign req_i.ready = (state_q == ST_IDLE);

  // slot match on the data read back
  always_comb begin
    case (req_q)
      REQ_INSERT: hit = !ram_rdata.used;
      default:    hit = ram_rdata.used && (ram_rdata.key == key_q);
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    req_d      = req_q;
    key_d      = key_q;
    val_d      = val_q;
    sh_d       = sh_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    cur_d      = cur_q;
    nxt_d      = nxt_q;
    n_d        = n_q;
    ram_we     = 1'b0;
    ram_addr   = nxt_q;
    ram_wdata  = '0;
    res_set    = 1'b0;
    res_status = STATUS_FAIL;
    res_key    = MISS_KEY;
    res_value  = MISS_VALUE;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + ADDR_W'(1);
        if (32'(clr_q) == TABLE_DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          req_d   = req_i.req_type;
          key_d   = req_i.key;
          val_d   = req_i.value;
          sh_d    = SH_W'(req_i.key);
          cnt_d   = '0;
          rem_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = mod_step(mod_step(rem_q, sh_q[SH_W-1], eff_size), sh_q[SH_W-2], eff_size);
        sh_d  = sh_q << 2;
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (32'(cnt_q) == DIV_STEPS - 1) begin
          state_d = ST_HOME;
        end
      end
      ST_HOME: begin
        if (out_free) begin
          if (!req_ok || (eff_probes == '0)) begin
            res_set = 1'b1;
            state_d = ST_IDLE;
          end else begin
            ram_addr = rem_q;
            cur_d    = rem_q;
            nxt_d    = next_slot(rem_q, eff_size);
            n_d      = CFG_PROBE_W'(1);
            state_d  = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (hit) begin
          res_set    = 1'b1;
          res_status = STATUS_OK;
          ram_we     = (req_q != REQ_SEARCH);
          ram_addr   = cur_q;
          if (req_q == REQ_INSERT) begin
            ram_wdata = '{used: 1'b1, key: key_q, data: val_q};
            res_key   = {1'b0, key_q};
            res_value = val_q;
          end else begin
            ram_wdata = '{used: 1'b0, key: ram_rdata.key, data: ram_rdata.data};
            res_key   = {1'b0, ram_rdata.key};
            res_value = ram_rdata.data;
          end
          state_d = ST_IDLE;
        end else if (n_q == eff_probes) begin
          res_set = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_addr = nxt_q;
          cur_d    = nxt_q;
          nxt_d    = next_slot(nxt_q, eff_size);
          n_d      = n_q + CFG_PROBE_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_valid_d = res_set || (rsp_valid_q && !rsp_o.ready);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    key_q <= key_d;
    val_q <= val_d;
    sh_q  <= sh_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    cur_q <= cur_d;
    nxt_q <= nxt_d;
    n_q   <= n_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_set) begin
      rsp_status_q <= res_status;
      rsp_key_q    <= res_key;
      rsp_value_q  <= res_value;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_key   = rsp_key_q;
  assign rsp_o.found_value = rsp_value_q;

  // slot memory
  lpht_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: design/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table unit, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      rsp_status_i,
  input logic [lpht_pkg::VAL_W-1:0] rsp_key_i,
  input logic [lpht_pkg::VAL_W-1:0] rsp_value_i
);

  import lpht_pkg::*;

  logic       req_xfer, rsp_xfer;
  logic [1:0] pend_q;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  // requests transferred but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(req_xfer) - 2'(rsp_xfer);
    end
  end

  // at most one request in work and one result waiting
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 2'd2)
    else $error("more than two requests outstanding");

  // no result without a request behind it
  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (pend_q != 2'd0))
    else $error("result without outstanding request");

  // a failed request reports the miss key and a zero value
  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i == STATUS_FAIL)) |->
      ((rsp_key_i == MISS_KEY) && (rsp_value_i == MISS_VALUE)))
    else $error("failed result with wrong fields");

  // a result never follows its request in the next cycle
  a_no_early_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && !rsp_valid_i) |=> !rsp_valid_i)
    else $error("result too early");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_key_i) && $stable(rsp_value_i)))
    else $error("stalled result changed");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_key_i    (rsp_o.found_key),
  .rsp_value_i  (rsp_o.found_value)
);

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear probing hash table unit. A mirror of the
// slot memory predicts every result from the accepted requests. Directed
// requests cover collisions, wrap, full, duplicates, removal and degenerate
// settings. Random phases then run under a range of table sizes and probe
// limits, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import lpht_pkg::*;

  // request code the block does not know
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int unsigned LIMIT            = 500000;
  localparam int unsigned SETTLE           = 40;
  localparam int unsigned PRESSURE_AT      = 120;
  localparam int unsigned PRESSURE_HOLD    = 300;
  localparam int unsigned RANDOM_PER_PHASE = 80;
  localparam int unsigned PHASES           = 10;
  localparam int unsigned POOL_DEPTH       = 24;
  localparam int unsigned MAX_REPORTS      = 10;

  typedef struct packed {
    logic   status;
    value_t fkey;
    value_t fval;
  } table_result_t;

  // mirror of the slot memory and the registers, plus results still due
  class hash_table_mirror;
    bit            slot_used [TABLE_DEPTH];
    key_t          slot_key  [TABLE_DEPTH];
    value_t        slot_data [TABLE_DEPTH];
    int unsigned   size_reg;
    int unsigned   probe_reg;
    table_result_t due_results[$];
    int unsigned   errors;
    int unsigned   n_requests, n_stored, n_full, n_found, n_missed;

    function new();
      size_reg  = TABLE_SIZE_RST;
      probe_reg = MAX_PROBES_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_TABLE_SIZE) begin
        size_reg = data[CFG_SIZE_W-1:0];
      end else begin
        probe_reg = data[CFG_PROBE_W-1:0];
      end
    endfunction

    // walk the table for one accepted request and queue what it returns
    function void apply_request(logic [1:0] op, key_t key, value_t value);
      int unsigned   size;
      int unsigned   probes;
      int unsigned   slot;
      table_result_t r;
      size   = (size_reg == 0) ? 1 : ((size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg);
      probes = (probe_reg > PROBE_CAP) ? PROBE_CAP : probe_reg;
      slot   = key % size;
      r.status = STATUS_FAIL;
      r.fkey   = MISS_KEY;
      r.fval   = MISS_VALUE;
      if (op == REQ_INSERT || op == REQ_SEARCH || op == REQ_REMOVE) begin
        for (int unsigned n = 0; n < probes; n++) begin
          if (op == REQ_INSERT) begin
            if (!slot_used[slot]) begin
              slot_used[slot] = 1'b1;
              slot_key[slot]  = key;
              slot_data[slot] = value;
              r.status = STATUS_OK;
              r.fkey   = value_t'({1'b0, key});
              r.fval   = value;
              break;
            end
          end else if (slot_used[slot] && slot_key[slot] == key) begin
            r.status = STATUS_OK;
            r.fkey   = value_t'({1'b0, slot_key[slot]});
            r.fval   = slot_data[slot];
            if (op == REQ_REMOVE) slot_used[slot] = 1'b0;
            break;
          end
          slot = (slot + 1 == size) ? 0 : slot + 1;
        end
      end
      n_requests++;
      if (op == REQ_INSERT) begin
        if (r.status == STATUS_OK) n_stored++; else n_full++;
      end else if (op == REQ_SEARCH || op == REQ_REMOVE) begin
        if (r.status == STATUS_OK) n_found++; else n_missed++;
      end
      due_results.push_back(r);
    endfunction

    // compare one result transfer with the oldest result due
    function void check_result(logic status, value_t fkey, value_t fval);
      table_result_t exp_r;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result with nothing due: status=%0b key=%0d value=%0d",
                   status, fkey, fval);
        return;
      end
      exp_r = due_results.pop_front();
      if (status !== exp_r.status || fkey !== exp_r.fkey || fval !== exp_r.fval) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: expected status=%0b key=%0d value=%0d, got status=%0b key=%0d value=%0d",
                   exp_r.status, exp_r.fkey, exp_r.fval, status, fkey, fval);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lpht_req_if req_if ();
  lpht_rsp_if rsp_if ();

  hash_table_mirror mirror;
  key_t             key_pool[$];
  int unsigned      idle_max;
  int unsigned      rsp_count;
  int unsigned      cycle_count;
  int unsigned      settings_count;

  linear_probe_hash_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap();
    return (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
  endfunction

  // mostly keys sent with an insert before, some clustered on home slots 0 to 3, some anywhere
  function automatic key_t pick_key(int unsigned size_cfg);
    int unsigned sel;
    int unsigned span;
    sel  = $urandom_range(0, 9);
    span = (size_cfg == 0) ? 1 : size_cfg;
    if (sel < 6 && key_pool.size() > 0) begin
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (sel < 8) begin
      return key_t'($urandom_range(0, 7) * span + $urandom_range(0, 3));
    end
    return key_t'($urandom);
  endfunction

  // write both registers on consecutive edges
  task automatic program_table(int unsigned size_val, int unsigned probe_val);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TABLE_SIZE;
    cfg_wdata <= CFG_DATA_W'(size_val);
    @(negedge clk_i);
    mirror.write_reg(CFG_TABLE_SIZE, CFG_DATA_W'(size_val));
    cfg_idx   <= CFG_MAX_PROBES;
    cfg_wdata <= CFG_DATA_W'(probe_val);
    @(negedge clk_i);
    mirror.write_reg(CFG_MAX_PROBES, CFG_DATA_W'(probe_val));
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // offer one request and hold it until the transfer
  task automatic send_request(logic [1:0] op, key_t key, value_t value);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.req_type <= req_type_e'(op);
    req_if.key      <= key;
    req_if.value    <= value;
    req_if.valid    <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    mirror.apply_request(op, key, value);
    @(negedge clk_i);
  endtask

  task automatic random_request(int unsigned size_cfg);
    int unsigned pick;
    logic [1:0]  op;
    key_t        key;
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = REQ_INSERT;
    else if (pick < 70) op = REQ_SEARCH;
    else if (pick < 95) op = REQ_REMOVE;
    else                op = REQ_UNKNOWN;
    key = pick_key(size_cfg);
    if (op == REQ_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
    send_request(op, key, value_t'($urandom));
  endtask

  // stop offering, wait for every result due, then let the block settle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result side: random stalls and one long hold-off
  initial begin : rsp_side
    int unsigned gap;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap();
      if (!held && rsp_count >= PRESSURE_AT) begin
        gap  = PRESSURE_HOLD;
        held = 1'b1;
      end
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      @(negedge clk_i);
    end
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      mirror.check_result(rsp_if.status, rsp_if.found_key, rsp_if.found_value);
      rsp_count++;
    end
  end

  // watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned phase_size  [PHASES];
    int unsigned phase_probes[PHASES];
    phase_size   = '{1, 2, 5, 16, 1024, 37, 3, 1000, 8, 64};
    phase_probes = '{1, 16, 3, 10, 16, 7, 2, 5, 31, 12};
    mirror          = new();
    idle_max        = 19;
    rsp_count       = 0;
    settings_count  = 0;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_TABLE_SIZE;
    cfg_wdata       = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_INSERT;
    req_if.key      = '0;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // small table: collisions, wrap, no stop at empty slots, duplicates, full
    program_table(8, 4);
    send_request(REQ_INSERT, 31'd0, value_t'(32'h7FFF_FFFF));
    send_request(REQ_INSERT, 31'd8, value_t'(32'h8000_0000));
    send_request(REQ_INSERT, 31'h7FFF_FFFF, value_t'(32'hFFFF_FFFF));
    send_request(REQ_INSERT, 31'd15, value_t'(32'd5));
    send_request(REQ_SEARCH, 31'd15, '0);
    send_request(REQ_SEARCH, 31'd8, '0);
    send_request(REQ_SEARCH, 31'd16, '0);
    send_request(REQ_REMOVE, 31'd8, '0);
    send_request(REQ_SEARCH, 31'd15, '0);
    send_request(REQ_INSERT, 31'd0, value_t'(32'd1));
    send_request(REQ_SEARCH, 31'd0, '0);
    send_request(REQ_REMOVE, 31'd0, '0);
    send_request(REQ_SEARCH, 31'd0, '0);
    send_request(REQ_INSERT, 31'd7, value_t'(32'd2));
    send_request(REQ_INSERT, 31'd23, value_t'(32'd3));
    send_request(REQ_UNKNOWN, 31'd0, value_t'(32'd9));
    drain();

    // probe limit zero: everything fails
    program_table(8, 0);
    send_request(REQ_INSERT, 31'd1, value_t'(32'd4));
    send_request(REQ_SEARCH, 31'd0, '0);
    drain();

    // oversized registers saturate; wrap from the last slot
    program_table(2047, 31);
    send_request(REQ_INSERT, 31'h7FFF_FFFF, value_t'(32'd6));
    send_request(REQ_INSERT, 31'h7FFF_FFFF, value_t'(32'd7));
    send_request(REQ_SEARCH, 31'd7, '0);
    drain();

    // size zero acts as one slot; upper slots unreachable after the shrink
    program_table(0, 16);
    send_request(REQ_SEARCH, 31'd15, '0);
    send_request(REQ_INSERT, 31'd12345, value_t'(32'd8));
    send_request(REQ_SEARCH, 31'd7, '0);
    send_request(REQ_REMOVE, 31'd7, '0);

    // random phases, some without idling
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      idle_max = (ph % 4 == 3) ? 0 : 19;
      program_table(phase_size[ph], phase_probes[ph]);
      repeat (RANDOM_PER_PHASE) random_request(phase_size[ph]);
    end
    drain();

    $display("covered %0d requests over %0d register settings, sizes 0 to 2047, probes 0 to 31",
             mirror.n_requests, settings_count);
    $display("inserts stored %0d, table full %0d, keys found %0d, keys missed %0d, bad results %0d",
             mirror.n_stored, mirror.n_full, mirror.n_found, mirror.n_missed, mirror.errors);
    if (mirror.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
